[design/msbce_pkg.sv]
// Package: shared types and constants for the multi-label BCE loss core.
`timescale 1ns / 1ps
package msbce_pkg;

    // Default sizing
    localparam int NumClassesDef    = 64;
    localparam int LogTableDepthDef = 256;

    // Field widths
    localparam int CmdW    = 2;
    localparam int LabelW  = 7;
    localparam int ProbW   = 16;
    localparam int ScaleW  = 16;
    localparam int GradW   = 21;
    localparam int MeanW   = 24;
    localparam int SumW    = 48;
    localparam int CountW  = 24;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 16;
    localparam int NlW     = 20;
    localparam int TermW   = 24;
    localparam int DivW    = 31;

    // Fixed-point constants
    localparam logic [19:0] Ln2Q16 = 20'd45426;
    localparam logic [31:0] Ln2Q32 = 32'd2977044472;
    localparam int          SqSteps  = 24;
    localparam int          DivSteps = 48;

    // Input commands
    typedef enum logic [CmdW-1:0] {
        CMD_LABEL  = 2'd0,
        CMD_PROB   = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_NEG_SCALE = 2'd0,
        REG_CLASSES   = 2'd1,
        REG_LABELS    = 2'd2,
        REG_UNUSED    = 2'd3
    } t_reg;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_LN,
        S_NEG,
        S_SCL,
        S_GRD,
        S_ACC,
        S_MUL,
        S_DIV,
        S_DONE,
        S_OUT
    } t_state;

endpackage

[design/multilabel_sigmoid_bce_loss_core.sv]
// Top level: multi-label sigmoid BCE loss core with a shared multiplier sequencer.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries i_cmd, i_label_index, i_prob.
//   Label items build the multi-hot target of a sample; probability items then
//   arrive in class order and each returns one gradient result; a finish item
//   returns the batch mean loss and starts a new batch.
//   Output channel (o_out_valid / i_out_ready) carries one result per probability or finish item.
//   Config channel (i_cfg_valid / o_cfg_ready) writes register i_cfg_index;
//   it is always ready; the user must write it only while the core is idle (not enforced).
// Sequencing:
//   Label and unused items give no result.
//   A probability item runs 24 squaring steps of the log evaluation on the one
//   32x32 multiplier, then the ln2 scale and, for label 0 only, the negative
//   weight and gradient products.
//   A finish item runs the 48-step restoring divider.
//   The core takes one item at a time; o_in_ready is low while it works.
// Reset (synchronous, active low) clears label state, accumulator, counts and
// restores register defaults. When the receiver stalls, the finished result
// holds in the output register and the core waits before loading the next one.
module multilabel_sigmoid_bce_loss_core #(
    parameter int NUM_CLASSES     = msbce_pkg::NumClassesDef,
    parameter int LOG_TABLE_DEPTH = msbce_pkg::LogTableDepthDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [msbce_pkg::CmdW-1:0]    i_cmd,
    input  logic [msbce_pkg::LabelW-1:0]  i_label_index,
    input  logic [msbce_pkg::ProbW-1:0]   i_prob,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_result_kind,
    output logic signed [msbce_pkg::GradW-1:0] o_gradient,
    output logic                          o_target_bit,
    output logic [msbce_pkg::MeanW-1:0]   o_mean_loss,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [msbce_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [msbce_pkg::CfgW-1:0]    i_cfg_data
);

    localparam int IdxW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int Ld     = $clog2(LOG_TABLE_DEPTH);
    localparam int LW     = msbce_pkg::LabelW;
    localparam int DivW_C = msbce_pkg::DivW;

    // Configuration registers
    logic [msbce_pkg::ScaleW-1:0] r_scale;
    logic [LW-1:0]                r_classes;
    logic [LW-1:0]                r_labels;

    // Sample and batch state
    logic [NUM_CLASSES-1:0]       r_bits;
    logic [LW-1:0]                r_pos;
    logic [LW-1:0]                r_seen;
    logic                         r_closed;
    logic [msbce_pkg::SumW-1:0]   r_sum;
    logic [msbce_pkg::CountW-1:0] r_count;

    // Sequencer and datapath
    msbce_pkg::t_state            r_state, n_state;
    logic [5:0]                   r_cnt;
    logic                         r_y;
    logic [msbce_pkg::ProbW-1:0]  r_p;
    logic [31:0]                  r_yv;
    logic [23:0]                  r_r;
    logic [63:0]                  r_prod;
    logic [msbce_pkg::NlW-1:0]    r_base;
    logic [msbce_pkg::NlW-1:0]    r_nl;
    logic [msbce_pkg::TermW-1:0]  r_term;
    logic signed [msbce_pkg::GradW-1:0] r_grad;
    logic [msbce_pkg::SumW-1:0]   r_dvd;
    logic [DivW_C-1:0]            r_div;
    logic [DivW_C-1:0]            r_rem;
    logic                         r_is_mean;
    logic [msbce_pkg::MeanW-1:0]  r_mean;

    // Output register
    logic                         r_ov;
    logic                         r_kind;
    logic signed [msbce_pkg::GradW-1:0] r_ograd;
    logic                         r_otbit;
    logic [msbce_pkg::MeanW-1:0]  r_omean;

    // Effective counts
    logic [LW-1:0] w_c;
    logic [LW-1:0] w_lim;
    always_comb begin
        w_c = (r_classes == '0) ? LW'(1) : r_classes;
        if (32'(w_c) > NUM_CLASSES) begin
            w_c = LW'(NUM_CLASSES);
        end
        w_lim = (r_labels == '0) ? LW'(1) : r_labels;
    end

    logic w_acc;
    assign w_acc       = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == msbce_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Probability item front end: class pick, log argument and exponent split
    logic [LW-1:0]  w_pos;
    logic           w_y;
    logic [16:0]    w_x;
    logic [4:0]     w_e;
    logic [16:0]    w_frac;
    logic [16+Ld:0] w_fsh;
    logic [Ld-1:0]  w_i;
    always_comb begin
        w_pos = (r_pos >= w_c) ? w_c - LW'(1) : r_pos;
        w_y   = r_bits[IdxW'(w_pos)];
        if (w_y) begin
            w_x = (i_prob == '0) ? 17'd1 : {1'b0, i_prob};
        end else begin
            w_x = 17'h10000 - {1'b0, i_prob};
        end
        w_e = '0;
        for (int k = 1; k < 17; k++) begin
            if (w_x[k]) begin
                w_e = 5'(k);
            end
        end
        w_frac = w_x - (17'd1 << w_e);
        w_fsh  = {w_frac, {Ld{1'b0}}} >> w_e;
        w_i    = w_fsh[Ld-1:0];
    end

    // Shared multiplier operand select
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    always_comb begin
        unique case (r_state)
            msbce_pkg::S_SQ: begin
                w_ma = r_yv;
                w_mb = r_yv;
            end
            msbce_pkg::S_LN: begin
                w_ma = 32'(r_r);
                w_mb = msbce_pkg::Ln2Q32;
            end
            msbce_pkg::S_SCL: begin
                w_ma = 32'(r_scale);
                w_mb = 32'(r_nl);
            end
            msbce_pkg::S_GRD: begin
                w_ma = 32'(r_scale);
                w_mb = 32'(r_p);
            end
            msbce_pkg::S_MUL: begin
                w_ma = 32'(r_count);
                w_mb = 32'(w_c);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod = w_ma * w_mb;
    end

    // Squaring step, rounding of the scaled log, accumulator sum and divider compare
    logic [63:0] w_sq;
    logic        w_sqbit;
    logic [23:0] w_t;
    logic [msbce_pkg::SumW:0] w_sum;
    logic [DivW_C:0] w_rsh;
    logic            w_qbit;
    always_comb begin
        w_sq    = w_prod >> 30;
        w_sqbit = (w_sq >= 64'h8000_0000);
        w_t     = 24'((r_prod + (64'd1 << 39)) >> 40);
        w_sum   = {1'b0, r_sum} + (msbce_pkg::SumW+1)'(r_term);
        w_rsh   = {r_rem, r_dvd[msbce_pkg::SumW-1]};
        w_qbit  = (w_rsh >= {1'b0, r_div});
    end

    logic w_out_free;
    assign w_out_free = !r_ov || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            msbce_pkg::S_IDLE: begin
                if (w_acc && i_cmd == msbce_pkg::CMD_PROB) begin
                    n_state = msbce_pkg::S_SQ;
                end else if (w_acc && i_cmd == msbce_pkg::CMD_FINISH) begin
                    n_state = msbce_pkg::S_MUL;
                end
            end
            msbce_pkg::S_SQ: begin
                if (r_cnt == 6'(msbce_pkg::SqSteps - 1)) begin
                    n_state = msbce_pkg::S_LN;
                end
            end
            msbce_pkg::S_LN:  n_state = msbce_pkg::S_NEG;
            msbce_pkg::S_NEG: n_state = r_y ? msbce_pkg::S_ACC : msbce_pkg::S_SCL;
            msbce_pkg::S_SCL: n_state = msbce_pkg::S_GRD;
            msbce_pkg::S_GRD: n_state = msbce_pkg::S_ACC;
            msbce_pkg::S_ACC: n_state = msbce_pkg::S_OUT;
            msbce_pkg::S_MUL: n_state = msbce_pkg::S_DIV;
            msbce_pkg::S_DIV: begin
                if (r_cnt == 6'(msbce_pkg::DivSteps - 1)) begin
                    n_state = msbce_pkg::S_DONE;
                end
            end
            msbce_pkg::S_DONE: n_state = msbce_pkg::S_OUT;
            msbce_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = msbce_pkg::S_IDLE;
                end
            end
            default: n_state = msbce_pkg::S_IDLE;
        endcase
    end

    // Control and batch state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= msbce_pkg::S_IDLE;
            r_scale   <= 16'd4096;
            r_classes <= LW'(64);
            r_labels  <= LW'(64);
            r_bits    <= '0;
            r_pos     <= '0;
            r_seen    <= '0;
            r_closed  <= 1'b0;
            r_sum     <= '0;
            r_count   <= '0;
            r_cnt     <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            // register writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    msbce_pkg::REG_NEG_SCALE: r_scale   <= i_cfg_data;
                    msbce_pkg::REG_CLASSES:   r_classes <= i_cfg_data[LW-1:0];
                    msbce_pkg::REG_LABELS:    r_labels  <= i_cfg_data[LW-1:0];
                    default: ;
                endcase
            end
            // item entry
            if (w_acc) begin
                case (i_cmd)
                    msbce_pkg::CMD_LABEL: begin
                        if (!r_closed) begin
                            if (i_label_index == '0) begin
                                r_closed <= 1'b1;
                            end else begin
                                if (i_label_index <= w_c) begin
                                    r_bits[IdxW'(i_label_index - LW'(1))] <= 1'b1;
                                end
                                r_seen <= r_seen + LW'(1);
                                if (r_seen + LW'(1) >= w_lim) begin
                                    r_closed <= 1'b1;
                                end
                            end
                        end
                    end
                    msbce_pkg::CMD_PROB: begin
                        if (w_pos + LW'(1) >= w_c) begin
                            if (r_count != {msbce_pkg::CountW{1'b1}}) begin
                                r_count <= r_count + msbce_pkg::CountW'(1);
                            end
                            r_bits   <= '0;
                            r_pos    <= '0;
                            r_seen   <= '0;
                            r_closed <= 1'b0;
                        end else begin
                            r_pos    <= w_pos + LW'(1);
                            r_closed <= 1'b1;
                        end
                    end
                    msbce_pkg::CMD_FINISH: begin
                        r_bits   <= '0;
                        r_pos    <= '0;
                        r_seen   <= '0;
                        r_closed <= 1'b0;
                        r_sum    <= '0;
                    end
                    default: ;
                endcase
            end
            // clear the sample count once the divisor has been formed from it
            if (r_state == msbce_pkg::S_MUL) begin
                r_count <= '0;
            end
            // step counter
            if (r_state == msbce_pkg::S_SQ || r_state == msbce_pkg::S_DIV) begin
                r_cnt <= r_cnt + 6'd1;
            end else begin
                r_cnt <= '0;
            end
            // accumulate with saturation
            if (r_state == msbce_pkg::S_ACC) begin
                r_sum <= w_sum[msbce_pkg::SumW] ? {msbce_pkg::SumW{1'b1}}
                                                : w_sum[msbce_pkg::SumW-1:0];
            end
            // output handshake
            if (r_state == msbce_pkg::S_OUT && w_out_free) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_y       <= w_y;
            r_p       <= i_prob;
            r_r       <= '0;
            r_yv      <= 32'({1'b1, w_i}) << (30 - Ld);
            r_base    <= msbce_pkg::NlW'((5'd16 - w_e) * msbce_pkg::Ln2Q16);
            r_grad    <= -$signed(msbce_pkg::GradW'(17'h10000 - {1'b0, i_prob}));
            r_dvd     <= r_sum;
            r_rem     <= '0;
            r_is_mean <= (i_cmd == msbce_pkg::CMD_FINISH);
        end
        unique case (r_state)
            msbce_pkg::S_SQ: begin
                r_r  <= {r_r[22:0], w_sqbit};
                r_yv <= w_sqbit ? w_sq[32:1] : w_sq[31:0];
            end
            msbce_pkg::S_LN: r_prod <= w_prod;
            msbce_pkg::S_NEG: begin
                r_nl   <= (32'(w_t) > 32'(r_base)) ? '0 : r_base - msbce_pkg::NlW'(w_t);
                r_term <= (32'(w_t) > 32'(r_base)) ? '0
                                                   : msbce_pkg::TermW'(r_base - msbce_pkg::NlW'(w_t));
            end
            msbce_pkg::S_SCL: r_term <= w_prod[12 +: msbce_pkg::TermW];
            msbce_pkg::S_GRD: r_grad <= $signed(w_prod[12 +: msbce_pkg::GradW]);
            msbce_pkg::S_MUL: r_div  <= w_prod[DivW_C-1:0];
            msbce_pkg::S_DIV: begin
                r_rem <= w_qbit ? DivW_C'(w_rsh - {1'b0, r_div}) : w_rsh[DivW_C-1:0];
                r_dvd <= {r_dvd[msbce_pkg::SumW-2:0], w_qbit};
            end
            msbce_pkg::S_DONE: begin
                if (r_div == '0) begin
                    r_mean <= '0;
                end else if (r_dvd[msbce_pkg::SumW-1:msbce_pkg::MeanW] != '0) begin
                    r_mean <= {msbce_pkg::MeanW{1'b1}};
                end else begin
                    r_mean <= r_dvd[msbce_pkg::MeanW-1:0];
                end
            end
            default: ;
        endcase
        // load the result register
        if (r_state == msbce_pkg::S_OUT && w_out_free) begin
            r_kind  <= r_is_mean;
            r_ograd <= r_is_mean ? '0 : r_grad;
            r_otbit <= r_is_mean ? 1'b0 : r_y;
            r_omean <= r_is_mean ? r_mean : '0;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_result_kind = r_kind;
    assign o_gradient    = r_ograd;
    assign o_target_bit  = r_otbit;
    assign o_mean_loss   = r_omean;

`ifndef SYNTHESIS
    a_prob_starts_log: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_cmd == msbce_pkg::CMD_PROB) |=> (r_state == msbce_pkg::S_SQ))
        else $error("probability item did not start the log sequence");
    a_sq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msbce_pkg::S_SQ) |-> (r_cnt < 6'(msbce_pkg::SqSteps)))
        else $error("squaring step count overrun");
    a_mean_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind) |-> (o_gradient == '0 && !o_target_bit))
        else $error("mean result carries gradient fields");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_mean_loss)))
        else $error("stalled result was overwritten");
`endif

endmodule
